// ===== src/sft_pkg.sv =====
package sft_pkg;

  // Link framing codes
  localparam logic [7:0] StartByte = 8'h80;
  localparam logic [7:0] EndByte   = 8'h81;
  localparam logic [6:0] BlankCode = 7'h7F;

  // Status frame layout
  localparam int unsigned FrameLen  = 12;
  localparam int unsigned StoreLen  = 9;   // status bytes s1..s9 are kept
  localparam int unsigned OutLen    = 11;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // Configuration register indexes
  localparam logic [1:0] CfgCoincide  = 2'd0;
  localparam logic [1:0] CfgDoorSound = 2'd1;

  // Display frame beat positions
  localparam logic [3:0] BeatStart = 4'd0;
  localparam logic [3:0] BeatZero0 = 4'd1;
  localparam logic [3:0] BeatZero1 = 4'd2;
  localparam logic [3:0] BeatTens  = 4'd3;
  localparam logic [3:0] BeatUnits = 4'd4;
  localparam logic [3:0] BeatBasic = 4'd5;
  localparam logic [3:0] BeatFunc1 = 4'd6;
  localparam logic [3:0] BeatFunc2 = 4'd7;
  localparam logic [3:0] BeatFunc3 = 4'd8;
  localparam logic [3:0] BeatCheck = 4'd9;
  localparam logic [3:0] BeatEnd   = 4'd10;

  typedef struct packed {
    logic coincide;
    logic door_sound;
  } sft_cfg_t;

  // One translated frame, the variable bytes only
  typedef struct packed {
    logic [7:0] tens;
    logic [7:0] units;
    logic [7:0] basicfun;
    logic [7:0] func1;
    logic [7:0] func2;
    logic [7:0] func3;
    logic [7:0] check;
  } frame_rec_t;

endpackage

// ===== src/sft_front.sv =====
module sft_front import sft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sft_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output frame_rec_t push_rec_o
);

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  buf_q [StoreLen];
  logic [14:0] last_floor_q, last_floor_d;
  logic [16:0] last_func_q, last_func_d;
  logic        talk_sent_q, talk_sent_d;
  logic [7:0]  prev_q [5];
  logic [7:0]  prev_d [5];

  logic        last_beat, accept;
  logic [3:0]  wr_idx;

  // Status bits
  logic [6:0]  s2_tens, s3_units;
  logic [14:0] floor_now;
  logic        floor_diff, floor_change;
  logic        closing, battery, digi, photo_cell, force_b, forbid, smoke, over, full;
  logic        maint, fire, lift, arrive, opening, down, up, run, talk, ts_cur;
  logic [7:0]  f1_raw, f2_raw;
  logic [16:0] word;
  logic        blank_rule;
  logic [7:0]  tens, units, basicfun, f1, f2, f3;

  assign last_beat    = (pos_q == 4'(FrameLen - 1));
  assign in_ready_o   = !(last_beat && !push_ready_i);
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = in_valid_i && last_beat;
  assign wr_idx       = pos_q - 4'd1;

  // Byte position: hunt for start, then count through the frame
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (pos_q == 4'd0) begin
        if (in_byte_i == StartByte) pos_d = 4'd1;
      end else if (last_beat) begin
        pos_d = 4'd0;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  // Status byte store, s1..s9
  always_ff @(posedge clk_i) begin
    if (accept && pos_q != 4'd0 && pos_q <= 4'(StoreLen)) begin
      buf_q[wr_idx] <= in_byte_i;
    end
  end

  // Translation of a complete frame
  always_comb begin
    s2_tens      = buf_q[1][6:0];
    s3_units     = buf_q[2][6:0];
    floor_now    = {s2_tens, 1'b0, s3_units};
    floor_diff   = (floor_now != last_floor_q);
    floor_change = floor_diff && cfg_i.coincide;

    battery    = !floor_change && buf_q[0][1];
    digi       = !floor_change && buf_q[0][0];
    closing    = !floor_change && buf_q[0][5];
    photo_cell = !floor_change && buf_q[3][4];
    force_b    = !floor_change && buf_q[3][5];
    forbid     = !floor_change && buf_q[3][6];
    smoke      = !floor_change && buf_q[4][0];
    over       = !floor_change && buf_q[4][2];
    full       = !floor_change && buf_q[4][3];
    maint      = !floor_change && buf_q[4][4];
    fire       = !floor_change && buf_q[4][5];
    lift       = !floor_change && buf_q[5][3];

    arrive  = buf_q[3][0];
    run     = buf_q[3][1];
    down    = buf_q[3][2];
    up      = buf_q[3][3];
    opening = cfg_i.door_sound && arrive;

    // One-shot talk latch, cleared on any floor difference
    ts_cur = talk_sent_q && !floor_diff;
    if (!ts_cur) begin
      talk        = buf_q[5][6];
      talk_sent_d = buf_q[5][6];
    end else begin
      talk        = closing && buf_q[5][6];
      talk_sent_d = 1'b1;
    end
    basicfun = {3'b000, talk, arrive, run, down, up};

    f1_raw = {1'b0, full, over, forbid, maint, battery, digi, photo_cell};
    f2_raw = {2'b00, smoke, 1'b0, force_b, fire, lift, 1'b0};
    word   = {closing, f2_raw, f1_raw};

    tens        = {1'b0, s2_tens};
    units       = {1'b0, s3_units};
    f1          = 8'd0;
    f2          = 8'd0;
    f3          = 8'd0;
    blank_rule  = 1'b0;
    last_func_d = last_func_q;
    last_floor_d = floor_diff ? floor_now : last_floor_q;

    if (!floor_change) begin
      f1 = f1_raw;
      f2 = f2_raw;
      f3 = {7'd0, closing};
      if (word != last_func_q) begin
        last_func_d = word;
        blank_rule  = 1'b1;
      end else if (buf_q[8][0]) begin
        // digits from the stored floor, which equals this frame's floor
        f1 = 8'd0;
        f2 = 8'd0;
        f3 = 8'd0;
      end else if (buf_q[8][2]) begin
        blank_rule = 1'b1;
      end else begin
        // repeat the previous display frame
        tens  = prev_q[0];
        units = prev_q[1];
        f1    = prev_q[2];
        f2    = prev_q[3];
        f3    = prev_q[4] | {6'd0, opening, 1'b0};
      end
      if (blank_rule) begin
        if (word != 17'd0 && cfg_i.coincide && !(closing || opening)) begin
          tens  = {1'b0, BlankCode};
          units = {1'b0, BlankCode};
        end
        f3 = f3 | {6'd0, opening, 1'b0};
      end
    end

    push_rec_o.tens     = tens;
    push_rec_o.units    = units;
    push_rec_o.basicfun = basicfun;
    push_rec_o.func1    = f1;
    push_rec_o.func2    = f2;
    push_rec_o.func3    = f3;
    push_rec_o.check    = tens ^ units ^ basicfun ^ f1 ^ f2 ^ {1'b0, f3[6:0]};

    prev_d[0] = tens;
    prev_d[1] = units;
    prev_d[2] = f1;
    prev_d[3] = f2;
    prev_d[4] = f3;
  end

  // Position and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 4'd0;
      last_floor_q <= 15'h7FFF;
      last_func_q  <= 17'd0;
      talk_sent_q  <= 1'b0;
      for (int i = 0; i < 5; i++) prev_q[i] <= 8'd0;
    end else begin
      pos_q <= pos_d;
      if (accept && last_beat) begin
        last_floor_q <= last_floor_d;
        last_func_q  <= last_func_d;
        talk_sent_q  <= talk_sent_d;
        for (int i = 0; i < 5; i++) prev_q[i] <= prev_d[i];
      end
    end
  end

endmodule

// ===== src/sft_queue.sv =====
module sft_queue import sft_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  frame_rec_t push_rec_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output frame_rec_t pop_rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_rec_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_rec_o    = mem_q[rd_ptr_q];

  // Record storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_rec_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== src/sft_back.sv =====
module sft_back import sft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rec_valid_i,
  output logic       rec_ready_o,
  input  frame_rec_t rec_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o
);

  logic [3:0] beat_q;
  logic       beat_done;

  assign out_valid_o = rec_valid_i;
  assign beat_done   = out_valid_o && out_ready_i;
  assign frame_end_o = (beat_q == BeatEnd);
  assign rec_ready_o = beat_done && frame_end_o;

  // Byte select for the current beat
  always_comb begin
    unique case (beat_q)
      BeatStart: out_byte_o = StartByte;
      BeatZero0: out_byte_o = 8'd0;
      BeatZero1: out_byte_o = 8'd0;
      BeatTens:  out_byte_o = rec_i.tens;
      BeatUnits: out_byte_o = rec_i.units;
      BeatBasic: out_byte_o = rec_i.basicfun;
      BeatFunc1: out_byte_o = rec_i.func1;
      BeatFunc2: out_byte_o = rec_i.func2;
      BeatFunc3: out_byte_o = rec_i.func3;
      BeatCheck: out_byte_o = rec_i.check;
      BeatEnd:   out_byte_o = EndByte;
      default:   out_byte_o = 8'd0;
    endcase
  end

  // Beat counter within the display frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= BeatStart;
    end else if (beat_done) begin
      beat_q <= frame_end_o ? BeatStart : beat_q + 4'd1;
    end
  end

endmodule

// ===== src/status_frame_translator.sv =====
// Status frame translator. Controller bytes enter one per beat on the input
// channel; bytes are dropped until a 0x80 start byte, which with the next
// eleven bytes forms a status frame. On the twelfth byte the frame is
// translated in that same cycle and an 11-byte display frame (0x80, 0, 0,
// tens, units, basic bits, three function bytes, XOR check, 0x81) is queued;
// frame_end_o marks the closing 0x81 beat. Input takes one byte per cycle and
// the output gives one byte per cycle while out_ready_i is high; the two
// sides are parted by a queue of QueueDepth translated frames, and the input
// stalls only on a frame's last byte while that queue is full. Configuration
// (index 0 coincide mode, index 1 door-open sound, data bit 0) is always
// ready and must be written while no frame is in flight.
module status_frame_translator import sft_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o
);

  sft_cfg_t   cfg_q;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  frame_rec_t push_rec, pop_rec;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCoincide:  cfg_q.coincide   <= cfg_data_i;
        CfgDoorSound: cfg_q.door_sound <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  sft_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec)
  );

  sft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (pop_valid),
    .rec_ready_o (pop_ready),
    .rec_i       (pop_rec),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sft_pkg::*;

  // Register indexes outside the map; writes to them must be ignored
  localparam logic [1:0] CfgSpare2 = 2'd2;
  localparam logic [1:0] CfgSpare3 = 2'd3;

  localparam int unsigned DrainCycles = 32;
  localparam int unsigned StatusBytes = 11;  // bytes after the start byte

  // s1..s11 of one status frame, entry k holds s(k+1)
  typedef logic [StatusBytes-1:0][7:0] frame_body_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } display_beat_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic       cfg_data_i  = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       frame_end_o;

  int in_gap_pct    = 30;
  int out_stall_pct = 30;
  int mismatch_count = 0;
  int beat_count     = 0;

  display_beat_t expected_beats[$];
  frame_body_t   sent_body = '0;

  // Translator state as seen by the checker
  logic [7:0]  status_buf [FrameLen];
  logic [3:0]  rx_pos;
  logic [14:0] last_floor_q;
  logic [16:0] last_word_q;
  logic        talk_sent_q;
  logic [7:0]  shown_q [5];  // tens, units, func1, func2, func3
  logic        coincide_q;
  logic        door_sound_q;

  status_frame_translator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Collects one link byte; on the twelfth byte of a frame it queues the display frame
  function automatic void take_status_byte(input logic [7:0] b);
    logic [7:0]  tens, units, basic, f1, f2, f3, chk;
    logic [14:0] floor_now;
    logic [16:0] word;
    logic        chg, closing, battery, digi, photo_cell, forced, forbid;
    logic        smoke, over, full, maint, fire, lift_on;
    logic        arrive, opening, up, down, run, talk, blank_rule;
    logic [7:0]  beats [OutLen];

    if (rx_pos == 4'd0) begin
      if (b == StartByte) begin
        status_buf[0] = b;
        rx_pos = 4'd1;
      end
      return;
    end
    status_buf[rx_pos] = b;
    if (rx_pos < FrameLen - 1) begin
      rx_pos++;
      return;
    end
    rx_pos = 4'd0;

    tens  = {1'b0, status_buf[2][6:0]};
    units = {1'b0, status_buf[3][6:0]};
    floor_now = {tens[6:0], units};
    chg = 1'b0;
    if (floor_now != last_floor_q) begin
      talk_sent_q  = 1'b0;
      last_floor_q = floor_now;
      chg = coincide_q;
    end

    // status bits count as zero on a coincide-mode floor change
    {battery, digi, closing, photo_cell, forced, forbid} = '0;
    {smoke, over, full, maint, fire, lift_on} = '0;
    if (!chg) begin
      battery    = status_buf[1][1];
      digi       = status_buf[1][0];
      closing    = status_buf[1][5];
      photo_cell = status_buf[4][4];
      forced     = status_buf[4][5];
      forbid     = status_buf[4][6];
      smoke      = status_buf[5][0];
      over       = status_buf[5][2];
      full       = status_buf[5][3];
      maint      = status_buf[5][4];
      fire       = status_buf[5][5];
      lift_on    = status_buf[6][3];
    end
    arrive  = status_buf[4][0];
    opening = door_sound_q & arrive;
    down    = status_buf[4][2];
    up      = status_buf[4][3];
    run     = status_buf[4][1];

    // talk is one-shot per floor unless the door is closing
    if (!talk_sent_q) begin
      talk = status_buf[6][6];
      if (talk) talk_sent_q = 1'b1;
    end else begin
      talk = closing & status_buf[6][6];
    end
    basic = {3'b000, talk, arrive, run, down, up};

    f1 = '0;
    f2 = '0;
    f3 = '0;
    if (!chg) begin
      f1 = {1'b0, full, over, forbid, maint, battery, digi, photo_cell};
      f2 = {2'b00, smoke, 1'b0, forced, fire, lift_on, 1'b0};
      f3 = {7'd0, closing};
      word = {closing, f2, f1};
      blank_rule = 1'b0;
      if (word != last_word_q) begin
        last_word_q = word;
        blank_rule  = 1'b1;
      end else if (status_buf[9][0]) begin
        tens  = {1'b0, last_floor_q[14:8]};
        units = {1'b0, last_floor_q[6:0]};
        f1 = '0;
        f2 = '0;
        f3 = '0;
      end else if (status_buf[9][2]) begin
        blank_rule = 1'b1;
      end else begin
        tens  = shown_q[0];
        units = shown_q[1];
        f1    = shown_q[2];
        f2    = shown_q[3];
        f3    = shown_q[4] | {6'd0, opening, 1'b0};
      end
      if (blank_rule) begin
        if (word != '0 && coincide_q && !(closing || opening)) begin
          tens  = {1'b0, BlankCode};
          units = {1'b0, BlankCode};
        end
        f3 = f3 | {6'd0, opening, 1'b0};
      end
    end

    chk = tens ^ units ^ basic ^ f1 ^ f2 ^ {1'b0, f3[6:0]};
    shown_q[0] = tens;
    shown_q[1] = units;
    shown_q[2] = f1;
    shown_q[3] = f2;
    shown_q[4] = f3;

    beats[BeatStart] = StartByte;
    beats[BeatZero0] = 8'h00;
    beats[BeatZero1] = 8'h00;
    beats[BeatTens]  = tens;
    beats[BeatUnits] = units;
    beats[BeatBasic] = basic;
    beats[BeatFunc1] = f1;
    beats[BeatFunc2] = f2;
    beats[BeatFunc3] = f3;
    beats[BeatCheck] = chk;
    beats[BeatEnd]   = EndByte;
    for (int k = 0; k < OutLen; k++) begin
      expected_beats.push_back('{byte_val: beats[k], last: (k == OutLen - 1)});
    end
  endfunction

  // Tracks accepted beats on all channels; input is predicted before output is checked
  always @(posedge clk_i or negedge rst_ni) begin
    display_beat_t exp_beat;
    if (!rst_ni) begin
      rx_pos       = '0;
      last_floor_q = '1;
      last_word_q  = '0;
      talk_sent_q  = 1'b0;
      coincide_q   = 1'b0;
      door_sound_q = 1'b0;
      foreach (shown_q[k]) shown_q[k] = '0;
      out_ready_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgCoincide:  coincide_q = cfg_data_i;
          CfgDoorSound: door_sound_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) take_status_byte(in_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("beat %0d: unexpected byte %02h", beat_count, out_byte_o));
        end else begin
          exp_beat = expected_beats.pop_front();
          if (out_byte_o !== exp_beat.byte_val) begin
            report_mismatch($sformatf("beat %0d: out_byte %02h, expected %02h",
                                      beat_count, out_byte_o, exp_beat.byte_val));
          end
          if (frame_end_o !== exp_beat.last) begin
            report_mismatch($sformatf("beat %0d: frame_end %b, expected %b",
                                      beat_count, frame_end_o, exp_beat.last));
          end
        end
        beat_count++;
      end
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Presents one byte, idling first at random; valid stays high for the next byte
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if ($urandom_range(99) < in_gap_pct) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_frame(input frame_body_t body);
    send_byte(StartByte);
    for (int k = 0; k < StatusBytes; k++) send_byte(body[k]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Input idle, every display frame out, and time for the block to settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic coincide, input logic door_sound);
    write_reg($urandom_range(1) ? CfgSpare2 : CfgSpare3, 1'($urandom));
    write_reg(CfgCoincide, coincide);
    write_reg(CfgDoorSound, door_sound);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic frame_body_t status_frame(input logic [7:0] s1, tens, units, s4, s5,
                                               s6, s9, fill);
    frame_body_t body;
    body = {StatusBytes{fill}};
    body[0] = s1;
    body[1] = tens;
    body[2] = units;
    body[3] = s4;
    body[4] = s5;
    body[5] = s6;
    body[8] = s9;
    return body;
  endfunction

  // Random frame that often keeps the floor or the function bytes of the previous one
  function automatic frame_body_t next_random_body();
    frame_body_t body;
    for (int k = 0; k < StatusBytes; k++) begin
      body[k] = ($urandom_range(9) == 0) ? StartByte : 8'($urandom);
    end
    if ($urandom_range(1)) begin
      body[1] = sent_body[1] ^ (($urandom_range(3) == 0) ? 8'h80 : 8'h00);
      body[2] = sent_body[2];
    end
    if ($urandom_range(99) < 60) begin
      body[0] = sent_body[0];
      body[3] = {sent_body[3][7:4], body[3][3:0]};
      body[4] = sent_body[4];
      body[5] = {sent_body[5][7], body[5][6], sent_body[5][5:0]};
    end
    // s9 picks between last-floor recall, reblank and plain repeat
    case ($urandom_range(3))
      0: ;
      1: body[8][0] = 1'b1;
      2: begin
        body[8][0] = 1'b0;
        body[8][2] = 1'b1;
      end
      default: begin
        body[8][0] = 1'b0;
        body[8][2] = 1'b0;
      end
    endcase
    sent_body = body;
    return body;
  endfunction

  task automatic run_random_frames(input int n_bytes);
    int         sent;
    logic [7:0] junk;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(3, 1)) begin
          junk = 8'($urandom);
          if (junk == StartByte) junk = ~junk;
          send_byte(junk);
        end
      end
      send_frame(next_random_body());
      sent += FrameLen;
    end
  endtask

  // Hunting drops junk; all-ones frame, then recall, reblank, repeat; 0x80 as data
  task automatic test_hunt_and_repeat();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(EndByte);
    send_byte(8'h7F);
    send_frame(status_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(status_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(status_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h04, 8'hFF));
    send_frame(status_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF));
    send_frame({StatusBytes{StartByte}});
    send_frame('0);
  endtask

  // Coincide mode with door-open sound: floor change, arrival, blanking, talk
  task automatic test_coincide_blanking();
    send_frame(status_frame(8'h00, 8'h03, 8'h05, 8'h01, 8'h01, 8'h40, 8'h00, 8'h00));
    send_frame(status_frame(8'h00, 8'h03, 8'h05, 8'h01, 8'h01, 8'h40, 8'h00, 8'h00));
    send_frame(status_frame(8'h00, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40, 8'h00, 8'h00));
    send_frame(status_frame(8'h20, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40, 8'h00, 8'h00));
  endtask

  task automatic test_random_traffic();
    set_mode(1'b0, 1'b0);
    run_random_frames(36);
    wait_drained();
    // a stretch with no idling on either side
    in_gap_pct    = 0;
    out_stall_pct = 0;
    set_mode(1'b1, 1'b1);
    run_random_frames(96);
    wait_drained();
    in_gap_pct    = 30;
    out_stall_pct = 30;
    set_mode(1'b1, 1'b0);
    run_random_frames(36);
    wait_drained();
    set_mode(1'b0, 1'b1);
    run_random_frames(36);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hunt_and_repeat();
    wait_drained();
    set_mode(1'b1, 1'b1);
    test_coincide_blanking();
    wait_drained();
    test_random_traffic();
    wait_drained();

    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
